// ===== rtl/hem_pkg.sv =====
package hem_pkg;

  typedef enum logic [1:0] {
    CMD_SRC   = 2'd0,
    CMD_TGT   = 2'd1,
    CMD_BUILD = 2'd2,
    CMD_MAP   = 2'd3
  } cmd_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic idx_clr;
    logic clr_wr;
    logic clr_map;
    logic cnt_rd;
    logic cnt_wr;
    logic s_acc;
    logic s_mul;
    logic t_acc;
    logic t_mul;
    logic e_mul;
    logic e_step;
    logic m_cmp;
    logic load_map;
    logic load_build;
  } ctrl_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic err;
    logic mode;
    logic i_last;
    logic j_last;
    logic hit;
    logic more;
    logic t_primed;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/hem_ctrl.sv =====
module hem_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [1:0]      cmd,
  output logic            in_stall,
  input  hem_pkg::stat_t  st,
  output hem_pkg::ctrl_t  ctl
);
  import hem_pkg::*;

  typedef enum logic [17:0] {
    ST_INIT  = 18'h00001,
    ST_IDLE  = 18'h00002,
    ST_C_RD  = 18'h00004,
    ST_C_WR  = 18'h00008,
    ST_M_RD  = 18'h00010,
    ST_M_OUT = 18'h00020,
    ST_B_SEL = 18'h00040,
    ST_S_RD  = 18'h00080,
    ST_S_ACC = 18'h00100,
    ST_S_MUL = 18'h00200,
    ST_T_RD  = 18'h00400,
    ST_T_ACC = 18'h00800,
    ST_T_MUL = 18'h01000,
    ST_M_CMP = 18'h02000,
    ST_E_MUL = 18'h04000,
    ST_E_STP = 18'h08000,
    ST_CLR   = 18'h10000,
    ST_B_OUT = 18'h20000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      ST_INIT: begin
        ctl.clr_wr  = 1'b1;
        ctl.clr_map = 1'b1;
        if (st.i_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          ctl.accept = 1'b1;
          case (cmd_t'(cmd))
            CMD_SRC, CMD_TGT: state_next = ST_C_RD;
            CMD_MAP:          state_next = ST_M_RD;
            default: begin
              ctl.idx_clr = 1'b1;
              state_next  = ST_B_SEL;
            end
          endcase
        end
      end
      ST_C_RD: begin
        ctl.cnt_rd = 1'b1;
        state_next = ST_C_WR;
      end
      ST_C_WR: begin
        ctl.cnt_wr = 1'b1;
        state_next = ST_IDLE;
      end
      ST_M_RD: state_next = ST_M_OUT;
      ST_M_OUT: begin
        if (st.out_free) begin
          ctl.load_map = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_B_SEL: state_next = st.err ? ST_CLR : ST_S_RD;
      ST_S_RD:  state_next = ST_S_ACC;
      ST_S_ACC: begin
        ctl.s_acc  = 1'b1;
        state_next = st.mode ? ST_S_MUL : ST_E_MUL;
      end
      ST_S_MUL: begin
        ctl.s_mul  = 1'b1;
        state_next = st.t_primed ? ST_M_CMP : ST_T_RD;
      end
      ST_T_RD:  state_next = ST_T_ACC;
      ST_T_ACC: begin
        ctl.t_acc  = 1'b1;
        state_next = ST_T_MUL;
      end
      ST_T_MUL: begin
        ctl.t_mul  = 1'b1;
        state_next = ST_M_CMP;
      end
      ST_M_CMP: begin
        ctl.m_cmp = 1'b1;
        if (st.hit || st.j_last) begin
          state_next = st.i_last ? ST_CLR : ST_S_RD;
        end else begin
          state_next = ST_T_RD;
        end
      end
      ST_E_MUL: begin
        ctl.e_mul  = 1'b1;
        state_next = ST_E_STP;
      end
      ST_E_STP: begin
        ctl.e_step = 1'b1;
        if (!st.more) state_next = st.i_last ? ST_CLR : ST_S_RD;
      end
      ST_CLR: begin
        ctl.clr_wr = 1'b1;
        if (st.i_last) state_next = ST_B_OUT;
      end
      ST_B_OUT: begin
        if (st.out_free) begin
          ctl.load_build = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_INIT;
    endcase
  end

endmodule

// ===== rtl/hem_dp.sv =====
module hem_dp #(
  parameter int BINS       = 256,
  parameter int COUNT_BITS = 22
) (
  input  logic            clk,
  input  logic            rst,
  input  hem_pkg::ctrl_t  ctl,
  output hem_pkg::stat_t  st,
  input  logic [1:0]      cmd,
  input  logic [7:0]      pixel_value,
  input  logic            cfg_valid,
  input  logic            cfg_data,
  input  logic            out_stall,
  output logic            out_valid,
  output logic [7:0]      mapped_value,
  output logic            build_done,
  output logic            empty_error,
  output logic            count_saturated
);
  import hem_pkg::*;

  localparam int IW = $clog2(BINS);
  localparam int CB = COUNT_BITS;
  localparam int BW = (CB > IW) ? CB : IW;
  localparam int PW = CB + BW;
  localparam int LW = (IW > 8) ? IW : 8;
  localparam logic [IW-1:0] LAST = IW'(BINS - 1);
  localparam logic [CB-1:0] CMAX = '1;

  logic [CB-1:0] src_mem [BINS];
  logic [CB-1:0] tgt_mem [BINS];
  logic [7:0]    map_mem [BINS];
  logic [CB-1:0] src_q, tgt_q;
  logic [7:0]    map_q;

  logic          mode;
  cmd_t          cmd_r;
  logic [IW-1:0] bin_r, i, j, k;
  logic [CB-1:0] srun, tcj, s_total, t_total;
  logic [PW:0]   acc;
  logic [PW-1:0] sprod, tprod, tprev;
  logic          err_r, t_primed, sat_flag;

  logic [LW-1:0] pix_ext, lvl_ext, k_ext;
  logic [IW-1:0] bin, lvl, src_ra, tgt_ra, i_inc;
  logic [CB:0]   s_sum, t_sum;
  logic [CB-1:0] mul_a;
  logic [BW-1:0] mul_b;
  logic [PW-1:0] prod;
  logic [PW:0]   pair, twice;
  logic [7:0]    lvl8, k8, map_wd;
  logic          hit, more, map_we, src_we, tgt_we;
  logic [CB-1:0] src_wd, tgt_wd;
  logic [IW-1:0] cnt_wa;

  // pixel clamp to the last bin
  assign pix_ext = LW'(pixel_value);
  assign bin     = (pix_ext > LW'(BINS - 1)) ? LAST : pix_ext[IW-1:0];

  assign i_inc = (i == LAST) ? '0 : i + 1'b1;
  assign hit   = (tprod >= sprod);
  assign more  = ((acc + (PW+1)'(s_total)) <= (PW+1)'(sprod));
  assign s_sum = {1'b0, srun} + {1'b0, src_q};
  assign t_sum = {1'b0, tcj} + {1'b0, tgt_q};

  // shared multiplier
  assign mul_a = ctl.t_mul ? tcj : srun;
  assign mul_b = ctl.t_mul ? BW'(s_total) : (ctl.s_mul ? BW'(t_total) : BW'(BINS - 1));
  assign prod  = PW'(mul_a) * PW'(mul_b);

  // nearest level: tie goes to the higher one
  assign pair  = {1'b0, tprod} + {1'b0, tprev};
  assign twice = {sprod, 1'b0};
  always_comb begin
    if (!hit) begin
      lvl = LAST;
    end else if ((j != '0) && (pair > twice)) begin
      lvl = j - 1'b1;
    end else begin
      lvl = j;
    end
  end
  assign lvl_ext = LW'(lvl);
  assign lvl8    = (lvl_ext > LW'(255)) ? 8'hff : lvl_ext[7:0];
  assign k_ext   = LW'(k);
  assign k8      = (k_ext > LW'(255)) ? 8'hff : k_ext[7:0];

  always_comb begin
    map_we = 1'b0;
    map_wd = '0;
    if (ctl.clr_wr && (ctl.clr_map || err_r)) begin
      map_we = 1'b1;
    end else if (ctl.m_cmp && (hit || j == LAST)) begin
      map_we = 1'b1;
      map_wd = lvl8;
    end else if (ctl.e_step && !more) begin
      map_we = 1'b1;
      map_wd = k8;
    end
  end

  assign cnt_wa = ctl.clr_wr ? i : bin_r;
  assign src_we = ctl.clr_wr || (ctl.cnt_wr && cmd_r == CMD_SRC && src_q != CMAX);
  assign tgt_we = ctl.clr_wr || (ctl.cnt_wr && cmd_r == CMD_TGT && tgt_q != CMAX);
  assign src_wd = ctl.clr_wr ? '0 : src_q + 1'b1;
  assign tgt_wd = ctl.clr_wr ? '0 : tgt_q + 1'b1;
  assign src_ra = ctl.cnt_rd ? bin_r : i;
  assign tgt_ra = ctl.cnt_rd ? bin_r : j;

  always_ff @(posedge clk) begin
    if (src_we) src_mem[cnt_wa] <= src_wd;
    if (tgt_we) tgt_mem[cnt_wa] <= tgt_wd;
    if (map_we) map_mem[i] <= map_wd;
    src_q <= src_mem[src_ra];
    tgt_q <= tgt_mem[tgt_ra];
    map_q <= map_mem[bin_r];
  end

  // sequencing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      i <= '0;
    end else if (ctl.idx_clr) begin
      i <= '0;
    end else if (ctl.clr_wr || map_we) begin
      i <= i_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_r <= cmd_t'(cmd);
      bin_r <= bin;
    end
    if (ctl.idx_clr) begin
      j        <= '0;
      srun     <= '0;
      tcj      <= '0;
      k        <= '0;
      acc      <= '0;
      t_primed <= 1'b0;
      err_r    <= (s_total == '0) || (mode && t_total == '0);
    end else begin
      if (ctl.s_acc) srun <= (s_sum > {1'b0, s_total}) ? s_total : s_sum[CB-1:0];
      if (ctl.t_acc) tcj <= (t_sum > {1'b0, t_total}) ? t_total : t_sum[CB-1:0];
      if (ctl.s_mul || ctl.e_mul) sprod <= prod;
      if (ctl.t_mul) begin
        tprev    <= tprod;
        tprod    <= prod;
        t_primed <= 1'b1;
      end
      if (ctl.m_cmp && !hit && j != LAST) j <= j + 1'b1;
      if (ctl.e_step && more) begin
        k   <= k + 1'b1;
        acc <= acc + (PW+1)'(s_total);
      end
    end
  end

  // totals, flag and mode
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= 1'b0;
      s_total  <= '0;
      t_total  <= '0;
      sat_flag <= 1'b0;
    end else begin
      if (cfg_valid) mode <= cfg_data;
      if (ctl.load_build) begin
        s_total  <= '0;
        t_total  <= '0;
        sat_flag <= 1'b0;
      end else if (ctl.cnt_wr) begin
        if (cmd_r == CMD_SRC) begin
          if (s_total == CMAX || src_q == CMAX) sat_flag <= 1'b1;
          if (s_total != CMAX) s_total <= s_total + 1'b1;
        end else begin
          if (t_total == CMAX || tgt_q == CMAX) sat_flag <= 1'b1;
          if (t_total != CMAX) t_total <= t_total + 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_map || ctl.load_build) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_map) begin
      mapped_value    <= map_q;
      build_done      <= 1'b0;
      empty_error     <= 1'b0;
      count_saturated <= sat_flag;
    end else if (ctl.load_build) begin
      mapped_value    <= '0;
      build_done      <= 1'b1;
      empty_error     <= err_r;
      count_saturated <= sat_flag;
    end
  end

  assign st.err      = (s_total == '0) || (mode && t_total == '0);
  assign st.mode     = mode;
  assign st.i_last   = (i == LAST);
  assign st.j_last   = (j == LAST);
  assign st.hit      = hit;
  assign st.more     = more;
  assign st.t_primed = t_primed;
  assign st.out_free = !out_valid || !out_stall;

endmodule

// ===== rtl/histogram_equalize_match_unit.sv =====
// channel | direction | handshake              | payload
// in      | input     | in_valid / in_stall    | cmd, pixel_value
// out     | output    | out_valid / out_stall  | mapped_value, build_done, empty_error,
//         |           |                        | count_saturated
// cfg     | input     | cfg_valid / cfg_ready  | cfg_data (mode)
//
// count commands read the bin's count, increment it and write it back
// map commands read the map table, plus any wait on the output register
// a build sweeps the source cdf bin by bin, running equalize steps for each bin
// or walking target bins in match mode, then clears both histograms
// after reset a clearing pass over all BINS entries runs with in_stall high
// a result waits in the output register while out_stall is high
module histogram_equalize_match_unit #(
  parameter int BINS       = 256,
  parameter int COUNT_BITS = 22
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] cmd,
  input  logic [7:0] pixel_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] mapped_value,
  output logic       build_done,
  output logic       empty_error,
  output logic       count_saturated,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);
  import hem_pkg::*;

  ctrl_t ctl;
  stat_t st;

  assign cfg_ready = 1'b1;

  hem_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .in_stall (in_stall),
    .st       (st),
    .ctl      (ctl)
  );

  hem_dp #(
    .BINS       (BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .st              (st),
    .cmd             (cmd),
    .pixel_value     (pixel_value),
    .cfg_valid       (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .mapped_value    (mapped_value),
    .build_done      (build_done),
    .empty_error     (empty_error),
    .count_saturated (count_saturated)
  );

  a_err_only_on_build: assert property (@(posedge clk) disable iff (rst)
    (out_valid && empty_error) |-> build_done)
    else $error("empty_error on a map result");

  a_build_zero_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && build_done) |-> (mapped_value == 8'd0))
    else $error("build result carries a map value");

  a_build_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && cmd == CMD_BUILD) |=> in_stall)
    else $error("input taken during a build");

  a_init_clear: assert property (@(posedge clk)
    $fell(rst) |-> in_stall)
    else $error("input open during the clearing pass");

endmodule
